// ----- hdl/qvr_pkg.sv -----
`default_nettype none

package qvr_pkg;

   localparam int COMP_BITS = 16;
   localparam int FRAC_BITS = 14;
   localparam int LANES     = 12;

   // first product q*v, sum of three, then shift
   localparam int PROD1_BITS = 2 * COMP_BITS;
   localparam int SUM1_BITS  = PROD1_BITS + 2;
   localparam int P_BITS     = SUM1_BITS - FRAC_BITS;

   // second product p*conj(q), sum of four, then shift
   localparam int PROD2_BITS = P_BITS + COMP_BITS;
   localparam int SUM2_BITS  = PROD2_BITS + 2;
   localparam int R_BITS     = SUM2_BITS - FRAC_BITS;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] quat_i;
      logic signed [COMP_BITS-1:0] quat_j;
      logic signed [COMP_BITS-1:0] quat_k;
      logic signed [COMP_BITS-1:0] quat_real;
      logic signed [COMP_BITS-1:0] vec_x;
      logic signed [COMP_BITS-1:0] vec_y;
      logic signed [COMP_BITS-1:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] rot_x;
      logic signed [COMP_BITS-1:0] rot_y;
      logic signed [COMP_BITS-1:0] rot_z;
      logic                        clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] quat_i;
      logic signed [COMP_BITS-1:0] quat_j;
      logic signed [COMP_BITS-1:0] quat_k;
      logic signed [COMP_BITS-1:0] quat_real;
   } quat_type;

endpackage

`default_nettype wire

// ----- hdl/qvr_mul_array.sv -----
`default_nettype none

module qvr_mul_array #(
   parameter int A_BITS = 16,
   parameter int B_BITS = 16,
   parameter int N      = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic signed [A_BITS-1:0]       a_in [N],
   input  wire logic signed [B_BITS-1:0]       b_in [N],
   output logic                                out_valid,
   output logic signed [A_BITS+B_BITS-1:0]     prod_out [N]
);

   localparam int P_W = A_BITS + B_BITS;

   logic                  valid_ff;
   logic signed [P_W-1:0] prod_in [N];
   logic signed [P_W-1:0] prod_ff [N];

   always_comb begin
      for (int n = 0; n < N; n++) begin
         prod_in[n] = P_W'(a_in[n]) * P_W'(b_in[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < N; n++) begin
         prod_ff[n] <= prod_in[n];
      end
   end

   assign out_valid = valid_ff;
   assign prod_out  = prod_ff;

endmodule

`default_nettype wire

// ----- hdl/quaternion_vector_rotate_unit.sv -----
// A result strobes once its transfer has passed through the 4 register stages.
// Throughput: one item per clock; busy is never raised, start is always taken.
// Stalls: none; the receiver cannot stall, so no result is ever held back.
// Stages: q*v products, first Hamilton sums, p*conj(q) products, sums and clamp.
// Reset clears the stage valid bits and the result strobe; data is not reset.
`default_nettype none

module quaternion_vector_rotate_unit
   import qvr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic signed [COMP_BITS-1:0]  mul1_a [LANES];
   logic signed [COMP_BITS-1:0]  mul1_b [LANES];
   logic                         mul1_valid;
   logic signed [PROD1_BITS-1:0] mul1_prod [LANES];

   quat_type                     q_s1_ff;
   quat_type                     q_s2_ff;
   logic                         s2_valid_ff;
   logic signed [P_BITS-1:0]     p_in [4];
   logic signed [P_BITS-1:0]     p_ff [4];
   logic signed [SUM1_BITS-1:0]  sum1 [4];

   logic signed [P_BITS-1:0]     mul2_a [LANES];
   logic signed [COMP_BITS-1:0]  mul2_b [LANES];
   logic                         mul2_valid;
   logic signed [PROD2_BITS-1:0] mul2_prod [LANES];

   logic signed [SUM2_BITS-1:0]  sum2 [3];
   logic [COMP_BITS:0]           sat [3];
   rsp_type                      rsp_in;
   rsp_type                      rsp_ff;
   logic                         rsp_strobe_ff;

   function automatic logic [COMP_BITS:0] saturate(input logic signed [R_BITS-1:0] value);
      logic [R_BITS-COMP_BITS:0] upper;
      logic [COMP_BITS:0]        res;
      upper = value[R_BITS-1:COMP_BITS-1];
      if ((&upper) || !(|upper)) begin
         res = {1'b0, value[COMP_BITS-1:0]};
      end else if (value[R_BITS-1]) begin
         res = {1'b1, 1'b1, {(COMP_BITS-1){1'b0}}};
      end else begin
         res = {1'b1, 1'b0, {(COMP_BITS-1){1'b1}}};
      end
      return res;
   endfunction

   assign busy = 1'b0;

   // stage 1: q * (v, 0) products
   always_comb begin
      mul1_a[0]  = req_data.quat_j;    mul1_b[0]  = req_data.vec_z;
      mul1_a[1]  = req_data.quat_k;    mul1_b[1]  = req_data.vec_y;
      mul1_a[2]  = req_data.quat_real; mul1_b[2]  = req_data.vec_x;
      mul1_a[3]  = req_data.quat_k;    mul1_b[3]  = req_data.vec_x;
      mul1_a[4]  = req_data.quat_i;    mul1_b[4]  = req_data.vec_z;
      mul1_a[5]  = req_data.quat_real; mul1_b[5]  = req_data.vec_y;
      mul1_a[6]  = req_data.quat_i;    mul1_b[6]  = req_data.vec_y;
      mul1_a[7]  = req_data.quat_j;    mul1_b[7]  = req_data.vec_x;
      mul1_a[8]  = req_data.quat_real; mul1_b[8]  = req_data.vec_z;
      mul1_a[9]  = req_data.quat_i;    mul1_b[9]  = req_data.vec_x;
      mul1_a[10] = req_data.quat_j;    mul1_b[10] = req_data.vec_y;
      mul1_a[11] = req_data.quat_k;    mul1_b[11] = req_data.vec_z;
   end

   qvr_mul_array #(
      .A_BITS (COMP_BITS),
      .B_BITS (COMP_BITS),
      .N      (LANES)
   ) u_mul1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .a_in      (mul1_a),
      .b_in      (mul1_b),
      .out_valid (mul1_valid),
      .prod_out  (mul1_prod)
   );

   always_ff @(posedge clock) begin
      q_s1_ff.quat_i    <= req_data.quat_i;
      q_s1_ff.quat_j    <= req_data.quat_j;
      q_s1_ff.quat_k    <= req_data.quat_k;
      q_s1_ff.quat_real <= req_data.quat_real;
   end

   // stage 2: first Hamilton sums, floor shift
   always_comb begin
      for (int g = 0; g < 3; g++) begin
         sum1[g] = SUM1_BITS'(mul1_prod[3*g]) - SUM1_BITS'(mul1_prod[3*g+1])
                 + SUM1_BITS'(mul1_prod[3*g+2]);
      end
      sum1[3] = -SUM1_BITS'(mul1_prod[9]) - SUM1_BITS'(mul1_prod[10])
              - SUM1_BITS'(mul1_prod[11]);
      for (int g = 0; g < 4; g++) begin
         p_in[g] = sum1[g][SUM1_BITS-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= mul1_valid;
      end
   end

   always_ff @(posedge clock) begin
      q_s2_ff <= q_s1_ff;
      for (int g = 0; g < 4; g++) begin
         p_ff[g] <= p_in[g];
      end
   end

   // stage 3: p * conj(q) products; p_ff order is x, y, z, real
   always_comb begin
      mul2_a[0]  = p_ff[1]; mul2_b[0]  = q_s2_ff.quat_k;
      mul2_a[1]  = p_ff[2]; mul2_b[1]  = q_s2_ff.quat_j;
      mul2_a[2]  = p_ff[0]; mul2_b[2]  = q_s2_ff.quat_real;
      mul2_a[3]  = p_ff[3]; mul2_b[3]  = q_s2_ff.quat_i;
      mul2_a[4]  = p_ff[2]; mul2_b[4]  = q_s2_ff.quat_i;
      mul2_a[5]  = p_ff[0]; mul2_b[5]  = q_s2_ff.quat_k;
      mul2_a[6]  = p_ff[1]; mul2_b[6]  = q_s2_ff.quat_real;
      mul2_a[7]  = p_ff[3]; mul2_b[7]  = q_s2_ff.quat_j;
      mul2_a[8]  = p_ff[0]; mul2_b[8]  = q_s2_ff.quat_j;
      mul2_a[9]  = p_ff[1]; mul2_b[9]  = q_s2_ff.quat_i;
      mul2_a[10] = p_ff[2]; mul2_b[10] = q_s2_ff.quat_real;
      mul2_a[11] = p_ff[3]; mul2_b[11] = q_s2_ff.quat_k;
   end

   qvr_mul_array #(
      .A_BITS (P_BITS),
      .B_BITS (COMP_BITS),
      .N      (LANES)
   ) u_mul2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .a_in      (mul2_a),
      .b_in      (mul2_b),
      .out_valid (mul2_valid),
      .prod_out  (mul2_prod)
   );

   // stage 4: second sums, floor shift, clamp
   always_comb begin
      for (int g = 0; g < 3; g++) begin
         sum2[g] = -SUM2_BITS'(mul2_prod[4*g]) + SUM2_BITS'(mul2_prod[4*g+1])
                 + SUM2_BITS'(mul2_prod[4*g+2]) - SUM2_BITS'(mul2_prod[4*g+3]);
         sat[g]  = saturate(sum2[g][SUM2_BITS-1:FRAC_BITS]);
      end
      rsp_in.rot_x   = sat[0][COMP_BITS-1:0];
      rsp_in.rot_y   = sat[1][COMP_BITS-1:0];
      rsp_in.rot_z   = sat[2][COMP_BITS-1:0];
      rsp_in.clipped = sat[0][COMP_BITS] | sat[1][COMP_BITS] | sat[2][COMP_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= mul2_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_from_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 4))
      else $error("result strobe without a transfer four cycles earlier");

   a_zero_quat_zero_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.quat_i == '0 && req_data.quat_j == '0
       && req_data.quat_k == '0 && req_data.quat_real == '0)
      |-> ##4 (rsp_strobe && rsp_data.rot_x == '0 && rsp_data.rot_y == '0
               && rsp_data.rot_z == '0 && !rsp_data.clipped))
      else $error("zero quaternion did not give a zero result");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.clipped) |->
      (rsp_data.rot_x == {1'b1, {(COMP_BITS-1){1'b0}}}
       || rsp_data.rot_x == {1'b0, {(COMP_BITS-1){1'b1}}}
       || rsp_data.rot_y == {1'b1, {(COMP_BITS-1){1'b0}}}
       || rsp_data.rot_y == {1'b0, {(COMP_BITS-1){1'b1}}}
       || rsp_data.rot_z == {1'b1, {(COMP_BITS-1){1'b0}}}
       || rsp_data.rot_z == {1'b0, {(COMP_BITS-1){1'b1}}}))
      else $error("clipped set with no component at a rail");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb
   import qvr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint REAL_ONE = 1 << FRAC_BITS;
   localparam longint COMP_MAX = (1 << (COMP_BITS - 1)) - 1;
   localparam longint COMP_MIN = -(1 << (COMP_BITS - 1));

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type expected_rot[$];
   int      idle_pct;
   int      transfer_count;
   int      result_count;
   int      clip_count;
   int      mismatch_count;

   quaternion_vector_rotate_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

   // r = q * (v,0) * conj(q), each product floored by the fraction shift, then clamped
   function automatic rsp_type rotate_expected(req_type item);
      longint qx, qy, qz, qw, vx, vy, vz;
      longint px, py, pz, pw;
      longint r[3];
      logic   clip;
      logic signed [COMP_BITS-1:0] c[3];
      rsp_type res;
      qx = longint'(item.quat_i);
      qy = longint'(item.quat_j);
      qz = longint'(item.quat_k);
      qw = longint'(item.quat_real);
      vx = longint'(item.vec_x);
      vy = longint'(item.vec_y);
      vz = longint'(item.vec_z);
      px = (qy * vz - qz * vy + qw * vx) >>> FRAC_BITS;
      py = (qz * vx - qx * vz + qw * vy) >>> FRAC_BITS;
      pz = (qx * vy - qy * vx + qw * vz) >>> FRAC_BITS;
      pw = (-qx * vx - qy * vy - qz * vz) >>> FRAC_BITS;
      r[0] = (-py * qz + pz * qy + px * qw - pw * qx) >>> FRAC_BITS;
      r[1] = (-pz * qx + px * qz + py * qw - pw * qy) >>> FRAC_BITS;
      r[2] = (-px * qy + py * qx + pz * qw - pw * qz) >>> FRAC_BITS;
      clip = 1'b0;
      for (int n = 0; n < 3; n++) begin
         if (r[n] > COMP_MAX) begin
            c[n] = COMP_MAX[COMP_BITS-1:0];
            clip = 1'b1;
         end else if (r[n] < COMP_MIN) begin
            c[n] = COMP_MIN[COMP_BITS-1:0];
            clip = 1'b1;
         end else begin
            c[n] = r[n][COMP_BITS-1:0];
         end
      end
      res.rot_x   = c[0];
      res.rot_y   = c[1];
      res.rot_z   = c[2];
      res.clipped = clip;
      return res;
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && start && !busy) begin
         expected_rot.push_back(rotate_expected(req_data));
         transfer_count++;
      end
      if (!reset && rsp_strobe) begin
         if (expected_rot.size() == 0) begin
            $error("unexpected result transfer: rot_x %0d rot_y %0d rot_z %0d",
                   rsp_data.rot_x, rsp_data.rot_y, rsp_data.rot_z);
            mismatch_count++;
         end else begin
            want = expected_rot.pop_front();
            result_count++;
            if (want.clipped) clip_count++;
            if (rsp_data.rot_x !== want.rot_x) begin
               $error("rot_x expected %0d actual %0d", want.rot_x, rsp_data.rot_x);
               mismatch_count++;
            end
            if (rsp_data.rot_y !== want.rot_y) begin
               $error("rot_y expected %0d actual %0d", want.rot_y, rsp_data.rot_y);
               mismatch_count++;
            end
            if (rsp_data.rot_z !== want.rot_z) begin
               $error("rot_z expected %0d actual %0d", want.rot_z, rsp_data.rot_z);
               mismatch_count++;
            end
            if (rsp_data.clipped !== want.clipped) begin
               $error("clipped expected %0b actual %0b", want.clipped, rsp_data.clipped);
               mismatch_count++;
            end
         end
      end
   end

   function automatic req_type make_item(int qi, int qj, int qk, int qr,
                                         int vx, int vy, int vz);
      req_type item;
      item.quat_i    = qi[COMP_BITS-1:0];
      item.quat_j    = qj[COMP_BITS-1:0];
      item.quat_k    = qk[COMP_BITS-1:0];
      item.quat_real = qr[COMP_BITS-1:0];
      item.vec_x     = vx[COMP_BITS-1:0];
      item.vec_y     = vy[COMP_BITS-1:0];
      item.vec_z     = vz[COMP_BITS-1:0];
      return item;
   endfunction

   // returns at the edge where the transfer happened; start stays high
   task automatic send_vector(req_type item);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic int vector_component();
      case ($urandom_range(3))
         0:       return $urandom_range(0, 255) - 128;
         1:       return $urandom_range(0, 8191) - 4096;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   task automatic test_directed();
      send_vector(make_item(0, 0, 0, 0, 0, 0, 0));
      send_vector(make_item(0, 0, 0, 16384, 1000, -2000, 3000));
      send_vector(make_item(0, 0, 0, 16384, 32767, -32768, -1));
      send_vector(make_item(0, 0, 0, -16384, -32768, 32767, 5));
      send_vector(make_item(11585, 0, 0, 11585, 100, 200, 300));
      send_vector(make_item(0, 16384, 0, 0, 12345, -23456, 32767));
      send_vector(make_item(0, 0, 16384, 0, -32768, 32767, 0));
      send_vector(make_item(8192, 8192, 8192, 8192, -5, 7, -9));
      send_vector(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_vector(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_vector(make_item(32767, 32767, 32767, 32767, -32768, -32768, -32768));
      send_vector(make_item(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
      send_vector(make_item(32767, -32768, 32767, -32768, -32768, 32767, -32768));
      send_vector(make_item(-32768, 0, 0, 0, 1, 1, 1));
      send_vector(make_item(1, 1, 1, 1, -1, -1, -1));
      send_vector(make_item(0, 0, 0, 1, 32767, 32767, 32767));
      send_vector(make_item(0, 0, 0, -1, -32768, -7, -1));
      send_vector(make_item(0, 0, 0, 32767, 32767, 32767, 32767));
      send_vector(make_item(0, 0, 0, 32767, -32768, -32768, -32768));
      send_vector(make_item(0, 0, 0, 16384, -1, 0, 1));
   endtask

   // mostly unit quaternions, some scaled to exercise the |q|^2 gain and clamping
   task automatic test_unit_rotations(int count);
      real    a[4];
      real    norm;
      real    gain;
      int     qc[4];
      for (int n = 0; n < count; n++) begin
         norm = 0.0;
         for (int m = 0; m < 4; m++) begin
            a[m] = (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
            norm += a[m] * a[m];
         end
         norm = $sqrt(norm);
         if (norm < 0.001) begin
            a[0] = 0.0;
            a[1] = 0.0;
            a[2] = 0.0;
            a[3] = 1.0;
            norm = 1.0;
         end
         gain = ($urandom_range(99) < 70) ? 1.0 : real'($urandom_range(25, 199)) / 100.0;
         for (int m = 0; m < 4; m++) begin
            qc[m] = $rtoi(a[m] / norm * gain * real'(REAL_ONE) + (a[m] >= 0.0 ? 0.5 : -0.5));
            if (qc[m] > COMP_MAX) qc[m] = int'(COMP_MAX);
            if (qc[m] < COMP_MIN) qc[m] = int'(COMP_MIN);
         end
         send_vector(make_item(qc[0], qc[1], qc[2], qc[3],
                               vector_component(), vector_component(), vector_component()));
      end
   endtask

   task automatic test_raw_patterns(int count);
      req_type item;
      for (int n = 0; n < count; n++) begin
         item.quat_i    = COMP_BITS'($urandom);
         item.quat_j    = COMP_BITS'($urandom);
         item.quat_k    = COMP_BITS'($urandom);
         item.quat_real = COMP_BITS'($urandom);
         item.vec_x     = COMP_BITS'($urandom);
         item.vec_y     = COMP_BITS'($urandom);
         item.vec_z     = COMP_BITS'($urandom);
         send_vector(item);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_rot.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      idle_pct       = 0;
      transfer_count = 0;
      result_count   = 0;
      clip_count     = 0;
      mismatch_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_unit_rotations(300);
      test_raw_patterns(200);

      idle_pct = 57;
      test_unit_rotations(250);
      test_raw_patterns(150);

      idle_pct = 9;
      test_unit_rotations(300);
      test_raw_patterns(200);

      drain_results();

      $display("Sent %0d transfers (directed, unit and scaled rotations, raw patterns)",
               transfer_count);
      $display("Checked %0d results, %0d of them clamped, sender gaps at 0/57/9 percent",
               result_count, clip_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
